// File: rtl/tcg_pkg.sv
// Shared types, widths, register indexes and reset values for the texture
// coordinate generation unit. No dependencies.
package tcg_pkg;

  localparam int COORD_FRAC_BITS_DEF = 16;

  localparam int CW       = 50;
  localparam int MW       = 49;
  localparam int LW       = 6;
  localparam int NMW      = 30;
  localparam int LEAD_POS = 29;
  localparam int SQW      = 62;
  localparam int NRW      = 31;
  localparam int SQ_N     = 31;

  localparam int MODE_ENVMAP   = 0;
  localparam int MODE_SCALE_S  = 1;
  localparam int MODE_SCALE_T  = 2;
  localparam int MODE_SCROLL_S = 3;
  localparam int MODE_SCROLL_T = 4;
  localparam int MODE_ROTATE   = 5;

  typedef enum logic [2:0] {
    CFG_MODE_FLAGS,
    CFG_SCALE,
    CFG_SCROLL,
    CFG_ROT,
    CFG_ROW0,
    CFG_ROW1,
    CFG_ROW2,
    CFG_TRANSLATION
  } tcg_cfg_e;

  localparam logic [5:0]  MODE_RST   = 6'd0;
  localparam logic [31:0] SCALE_RST  = 32'h0100_0100;
  localparam logic [63:0] SCROLL_RST = 64'd0;
  localparam logic [31:0] ROT_RST    = 32'h0000_4000;
  localparam logic [47:0] ROW0_RST   = 48'h0000_0000_4000;
  localparam logic [47:0] ROW1_RST   = 48'h0000_4000_0000;
  localparam logic [47:0] ROW2_RST   = 48'h4000_0000_0000;
  localparam logic [62:0] TRANS_RST  = 63'd0;

  typedef struct packed {
    logic en;
    logic valid;
  } tcg_ctl_t;

endpackage

// File: rtl/tcg_unitvec.sv
// Pipelined normalisation of a transformed vector: magnitude, shift,
// square root and division, one vector per cycle while enabled. Depends on tcg_pkg.
module tcg_unitvec #(
  parameter int FRAC   = tcg_pkg::COORD_FRAC_BITS_DEF,
  parameter int SIDE_W = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tcg_pkg::tcg_ctl_t             ctl_i,
  input  logic signed [tcg_pkg::CW-1:0] c0_i,
  input  logic signed [tcg_pkg::CW-1:0] c1_i,
  input  logic signed [tcg_pkg::CW-1:0] c2_i,
  input  logic [SIDE_W-1:0]             side_i,
  output logic                          valid_o,
  output logic [SIDE_W-1:0]             side_o,
  output logic signed [FRAC+1:0]        s_o,
  output logic signed [FRAC+1:0]        t_o
);

  localparam int MW    = tcg_pkg::MW;
  localparam int NMW   = tcg_pkg::NMW;
  localparam int SQW   = tcg_pkg::SQW;
  localparam int NRW   = tcg_pkg::NRW;
  localparam int SQ_N  = tcg_pkg::SQ_N;
  localparam int QW    = FRAC + 1;
  localparam int NW    = FRAC + 32;
  localparam int DIV_N = FRAC + 1;

  logic en;
  assign en = ctl_i.en;

  // Magnitudes and sign.
  logic              u1_v_q;
  logic [MW-1:0]     u1_m_q [3];
  logic [MW-1:0]     u1_or_q;
  logic [1:0]        u1_sgn_q;
  logic [SIDE_W-1:0] u1_side_q;
  logic [MW-1:0]     u1_m_d [3];
  logic signed [tcg_pkg::CW-1:0] a0, a1, a2;

  always_comb begin
    a0 = c0_i[tcg_pkg::CW-1] ? -c0_i : c0_i;
    a1 = c1_i[tcg_pkg::CW-1] ? -c1_i : c1_i;
    a2 = c2_i[tcg_pkg::CW-1] ? -c2_i : c2_i;
    u1_m_d[0] = a0[MW-1:0];
    u1_m_d[1] = a1[MW-1:0];
    u1_m_d[2] = a2[MW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      u1_m_q    <= u1_m_d;
      u1_or_q   <= u1_m_d[0] | u1_m_d[1] | u1_m_d[2];
      u1_sgn_q  <= {c1_i[tcg_pkg::CW-1], c0_i[tcg_pkg::CW-1]};
      u1_side_q <= side_i;
    end
  end

  // Leading one of the largest magnitude.
  logic                  u2_v_q;
  logic [tcg_pkg::LW-1:0] u2_lead_q, u2_lead_d;
  logic                  u2_zero_q;
  logic [MW-1:0]         u2_m_q [3];
  logic [1:0]            u2_sgn_q;
  logic [SIDE_W-1:0]     u2_side_q;

  always_comb begin
    u2_lead_d = '0;
    for (int i = 0; i < MW; i++) begin
      if (u1_or_q[i]) begin
        u2_lead_d = tcg_pkg::LW'(i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      u2_lead_q <= u2_lead_d;
      u2_zero_q <= (u1_or_q == '0);
      u2_m_q    <= u1_m_q;
      u2_sgn_q  <= u1_sgn_q;
      u2_side_q <= u1_side_q;
    end
  end

  // Common shift so that the largest lies just below 2^30.
  logic              u3_v_q;
  logic [NMW-1:0]    u3_m_q [3];
  logic [NMW-1:0]    u3_m_d [3];
  logic              u3_zero_q;
  logic [1:0]        u3_sgn_q;
  logic [SIDE_W-1:0] u3_side_q;
  logic [MW-1:0]     sh_tmp;

  always_comb begin
    sh_tmp = '0;
    for (int i = 0; i < 3; i++) begin
      if (u2_lead_q >= tcg_pkg::LW'(tcg_pkg::LEAD_POS)) begin
        sh_tmp = u2_m_q[i] >> (u2_lead_q - tcg_pkg::LW'(tcg_pkg::LEAD_POS));
      end else begin
        sh_tmp = u2_m_q[i] << (tcg_pkg::LW'(tcg_pkg::LEAD_POS) - u2_lead_q);
      end
      u3_m_d[i] = sh_tmp[NMW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      u3_m_q    <= u3_m_d;
      u3_zero_q <= u2_zero_q;
      u3_sgn_q  <= u2_sgn_q;
      u3_side_q <= u2_side_q;
    end
  end

  // Squares.
  logic              u4_v_q;
  logic [2*NMW-1:0]  u4_sq_q [3];
  logic [NMW-1:0]    u4_m0_q, u4_m1_q;
  logic              u4_zero_q;
  logic [1:0]        u4_sgn_q;
  logic [SIDE_W-1:0] u4_side_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        u4_sq_q[i] <= (2*NMW)'(u3_m_q[i]) * (2*NMW)'(u3_m_q[i]);
      end
      u4_m0_q   <= u3_m_q[0];
      u4_m1_q   <= u3_m_q[1];
      u4_zero_q <= u3_zero_q;
      u4_sgn_q  <= u3_sgn_q;
      u4_side_q <= u3_side_q;
    end
  end

  // Sum of squares.
  logic              u5_v_q;
  logic [SQW-1:0]    u5_sum_q;
  logic [NMW-1:0]    u5_m0_q, u5_m1_q;
  logic              u5_zero_q;
  logic [1:0]        u5_sgn_q;
  logic [SIDE_W-1:0] u5_side_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      u5_sum_q  <= SQW'(u4_sq_q[0]) + SQW'(u4_sq_q[1]) + SQW'(u4_sq_q[2]);
      u5_m0_q   <= u4_m0_q;
      u5_m1_q   <= u4_m1_q;
      u5_zero_q <= u4_zero_q;
      u5_sgn_q  <= u4_sgn_q;
      u5_side_q <= u4_side_q;
    end
  end

  // Square root, one result bit per stage.
  logic              sr_v_q    [SQ_N];
  logic [SQW-1:0]    sr_x_q    [SQ_N];
  logic [SQW-1:0]    sr_r_q    [SQ_N];
  logic [NMW-1:0]    sr_m0_q   [SQ_N];
  logic [NMW-1:0]    sr_m1_q   [SQ_N];
  logic              sr_zero_q [SQ_N];
  logic [1:0]        sr_sgn_q  [SQ_N];
  logic [SIDE_W-1:0] sr_side_q [SQ_N];

  for (genvar k = 0; k < SQ_N; k++) begin : g_sqrt
    localparam int BP = 2 * (SQ_N - 1 - k);
    logic              v_in, zero_in, take;
    logic [SQW-1:0]    x_in, r_in, bit_c, trial;
    logic [NMW-1:0]    m0_in, m1_in;
    logic [1:0]        sgn_in;
    logic [SIDE_W-1:0] side_in;

    if (k == 0) begin : g_first
      assign v_in    = u5_v_q;
      assign x_in    = u5_sum_q;
      assign r_in    = '0;
      assign m0_in   = u5_m0_q;
      assign m1_in   = u5_m1_q;
      assign zero_in = u5_zero_q;
      assign sgn_in  = u5_sgn_q;
      assign side_in = u5_side_q;
    end else begin : g_next
      assign v_in    = sr_v_q[k-1];
      assign x_in    = sr_x_q[k-1];
      assign r_in    = sr_r_q[k-1];
      assign m0_in   = sr_m0_q[k-1];
      assign m1_in   = sr_m1_q[k-1];
      assign zero_in = sr_zero_q[k-1];
      assign sgn_in  = sr_sgn_q[k-1];
      assign side_in = sr_side_q[k-1];
    end

    assign bit_c = {{(SQW-1){1'b0}}, 1'b1} << BP;
    assign trial = r_in + bit_c;
    assign take  = (x_in >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sr_v_q[k] <= 1'b0;
      end else if (en) begin
        sr_v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        sr_x_q[k]    <= take ? (x_in - trial) : x_in;
        sr_r_q[k]    <= take ? ((r_in >> 1) + bit_c) : (r_in >> 1);
        sr_m0_q[k]   <= m0_in;
        sr_m1_q[k]   <= m1_in;
        sr_zero_q[k] <= zero_in;
        sr_sgn_q[k]  <= sgn_in;
        sr_side_q[k] <= side_in;
      end
    end
  end

  // Rounded dividends.
  logic              d0_v_q;
  logic [NW-1:0]     d0_rs_q, d0_rt_q;
  logic [NRW-1:0]    d0_n_q;
  logic              d0_zero_q;
  logic [1:0]        d0_sgn_q;
  logic [SIDE_W-1:0] d0_side_q;
  logic [NRW-1:0]    root;

  assign root = sr_r_q[SQ_N-1][NRW-1:0];

  always_ff @(posedge clk_i) begin
    if (en) begin
      d0_rs_q   <= (NW'(sr_m0_q[SQ_N-1]) << FRAC) + NW'(root >> 1);
      d0_rt_q   <= (NW'(sr_m1_q[SQ_N-1]) << FRAC) + NW'(root >> 1);
      d0_n_q    <= root;
      d0_zero_q <= sr_zero_q[SQ_N-1];
      d0_sgn_q  <= sr_sgn_q[SQ_N-1];
      d0_side_q <= sr_side_q[SQ_N-1];
    end
  end

  // Restoring division, one quotient bit per stage.
  logic              dv_v_q    [DIV_N];
  logic [NW-1:0]     dv_rs_q   [DIV_N];
  logic [NW-1:0]     dv_rt_q   [DIV_N];
  logic [QW-1:0]     dv_qs_q   [DIV_N];
  logic [QW-1:0]     dv_qt_q   [DIV_N];
  logic [NRW-1:0]    dv_n_q    [DIV_N];
  logic              dv_zero_q [DIV_N];
  logic [1:0]        dv_sgn_q  [DIV_N];
  logic [SIDE_W-1:0] dv_side_q [DIV_N];

  for (genvar i = 0; i < DIV_N; i++) begin : g_div
    localparam int J = FRAC - i;
    logic              v_in, zero_in, take_s, take_t;
    logic [NW-1:0]     rs_in, rt_in, dsh;
    logic [QW-1:0]     qs_in, qt_in;
    logic [NRW-1:0]    n_in;
    logic [1:0]        sgn_in;
    logic [SIDE_W-1:0] side_in;

    if (i == 0) begin : g_first
      assign v_in    = d0_v_q;
      assign rs_in   = d0_rs_q;
      assign rt_in   = d0_rt_q;
      assign qs_in   = '0;
      assign qt_in   = '0;
      assign n_in    = d0_n_q;
      assign zero_in = d0_zero_q;
      assign sgn_in  = d0_sgn_q;
      assign side_in = d0_side_q;
    end else begin : g_next
      assign v_in    = dv_v_q[i-1];
      assign rs_in   = dv_rs_q[i-1];
      assign rt_in   = dv_rt_q[i-1];
      assign qs_in   = dv_qs_q[i-1];
      assign qt_in   = dv_qt_q[i-1];
      assign n_in    = dv_n_q[i-1];
      assign zero_in = dv_zero_q[i-1];
      assign sgn_in  = dv_sgn_q[i-1];
      assign side_in = dv_side_q[i-1];
    end

    assign dsh    = NW'(n_in) << J;
    assign take_s = (rs_in >= dsh);
    assign take_t = (rt_in >= dsh);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_v_q[i] <= 1'b0;
      end else if (en) begin
        dv_v_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_rs_q[i]   <= take_s ? (rs_in - dsh) : rs_in;
        dv_rt_q[i]   <= take_t ? (rt_in - dsh) : rt_in;
        dv_qs_q[i]   <= qs_in | (QW'(take_s) << J);
        dv_qt_q[i]   <= qt_in | (QW'(take_t) << J);
        dv_n_q[i]    <= n_in;
        dv_zero_q[i] <= zero_in;
        dv_sgn_q[i]  <= sgn_in;
        dv_side_q[i] <= side_in;
      end
    end
  end

  // Signed result; a zero vector gives zero.
  logic                   o_v_q;
  logic signed [FRAC+1:0] o_s_q, o_t_q;
  logic [SIDE_W-1:0]      o_side_q;
  logic signed [FRAC+1:0] qs_ext, qt_ext;

  assign qs_ext = $signed((FRAC+2)'(dv_qs_q[DIV_N-1]));
  assign qt_ext = $signed((FRAC+2)'(dv_qt_q[DIV_N-1]));

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (dv_zero_q[DIV_N-1]) begin
        o_s_q <= '0;
        o_t_q <= '0;
      end else begin
        o_s_q <= dv_sgn_q[DIV_N-1][0] ? -qs_ext : qs_ext;
        o_t_q <= dv_sgn_q[DIV_N-1][1] ? -qt_ext : qt_ext;
      end
      o_side_q <= dv_side_q[DIV_N-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      u1_v_q <= 1'b0;
      u2_v_q <= 1'b0;
      u3_v_q <= 1'b0;
      u4_v_q <= 1'b0;
      u5_v_q <= 1'b0;
      d0_v_q <= 1'b0;
      o_v_q  <= 1'b0;
    end else if (en) begin
      u1_v_q <= ctl_i.valid;
      u2_v_q <= u1_v_q;
      u3_v_q <= u2_v_q;
      u4_v_q <= u3_v_q;
      u5_v_q <= u4_v_q;
      d0_v_q <= sr_v_q[SQ_N-1];
      o_v_q  <= dv_v_q[DIV_N-1];
    end
  end

  assign valid_o = o_v_q;
  assign side_o  = o_side_q;
  assign s_o     = o_s_q;
  assign t_o     = o_t_q;

`ifndef NO_ASSERTIONS
  a_root_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sr_v_q[SQ_N-1] && !sr_zero_q[SQ_N-1]) |->
      (root >= (NRW'(1) << tcg_pkg::LEAD_POS)) && !root[NRW-1] ||
      (root >= (NRW'(1) << tcg_pkg::LEAD_POS)) && (root < NRW'(32'd1859775394)))
    else $error("root of normalised vector out of range");

  a_quot_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dv_v_q[DIV_N-1] && !dv_zero_q[DIV_N-1]) |->
      (dv_qs_q[DIV_N-1] <= (QW'(1) << FRAC)) && (dv_qt_q[DIV_N-1] <= (QW'(1) << FRAC)))
    else $error("unit vector component exceeds one");
`endif

endmodule

// File: rtl/texcoord_generate_transform.sv
// Throughput: one beat per cycle while no result is stalled, set by the fully
// pipelined square root and divider stages. A stalled result moves into an
// output skid register, and from the next cycle the whole pipeline, input
// included, holds until that beat is taken.
// Reset clears all valid bits and loads the register defaults.
module texcoord_generate_transform #(
  parameter int COORD_FRAC_BITS = tcg_pkg::COORD_FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [63:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic signed [31:0] tex_s_i,
  input  logic signed [31:0] tex_t_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] out_s_o,
  output logic signed [31:0] out_t_o,
  output logic               saturated_o
);

  localparam int CW = tcg_pkg::CW;
  localparam int UW = COORD_FRAC_BITS + 2;
  localparam longint HALF = 64'sd1 <<< (COORD_FRAC_BITS - 1);

  logic [5:0]  mode_q;
  logic [31:0] scale_q;
  logic [63:0] scroll_q;
  logic [31:0] rot_q;
  logic [47:0] mat_q [3];
  logic [62:0] trans_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= tcg_pkg::MODE_RST;
      scale_q  <= tcg_pkg::SCALE_RST;
      scroll_q <= tcg_pkg::SCROLL_RST;
      rot_q    <= tcg_pkg::ROT_RST;
      mat_q[0] <= tcg_pkg::ROW0_RST;
      mat_q[1] <= tcg_pkg::ROW1_RST;
      mat_q[2] <= tcg_pkg::ROW2_RST;
      trans_q  <= tcg_pkg::TRANS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tcg_pkg::CFG_MODE_FLAGS:  mode_q   <= cfg_wdata_i[5:0];
        tcg_pkg::CFG_SCALE:       scale_q  <= cfg_wdata_i[31:0];
        tcg_pkg::CFG_SCROLL:      scroll_q <= cfg_wdata_i;
        tcg_pkg::CFG_ROT:         rot_q    <= cfg_wdata_i[31:0];
        tcg_pkg::CFG_ROW0:        mat_q[0] <= cfg_wdata_i[47:0];
        tcg_pkg::CFG_ROW1:        mat_q[1] <= cfg_wdata_i[47:0];
        tcg_pkg::CFG_ROW2:        mat_q[2] <= cfg_wdata_i[47:0];
        tcg_pkg::CFG_TRANSLATION: trans_q  <= cfg_wdata_i[62:0];
        default: ;
      endcase
    end
  end

  logic en;
  logic sk_v_q;
  assign en         = !sk_v_q;
  assign in_stall_o = sk_v_q;

  // Stage 1: matrix products.
  logic               t1_v_q;
  logic signed [47:0] t1_prod_q [9];
  logic [63:0]        t1_side_q;
  logic signed [31:0] pos [3];

  assign pos[0] = pos_x_i;
  assign pos[1] = pos_y_i;
  assign pos[2] = pos_z_i;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        for (int j = 0; j < 3; j++) begin
          t1_prod_q[3*r+j] <= pos[j] * $signed(mat_q[r][16*j +: 16]);
        end
      end
      t1_side_q <= {tex_t_i, tex_s_i};
    end
  end

  // Stage 2: row sums with translation.
  logic                 t2_v_q;
  logic signed [CW-1:0] t2_c_q [3];
  logic [63:0]          t2_side_q;
  logic signed [34:0]   tr_term [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      tr_term[r] = $signed({trans_q[21*r +: 21], 14'b0});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        t2_c_q[r] <= CW'(t1_prod_q[3*r]) + CW'(t1_prod_q[3*r+1]) +
                     CW'(t1_prod_q[3*r+2]) + CW'(tr_term[r]);
      end
      t2_side_q <= t1_side_q;
    end
  end

  tcg_pkg::tcg_ctl_t  u_ctl;
  logic               u_valid;
  logic [63:0]        u_side;
  logic signed [UW-1:0] u_s, u_t;

  assign u_ctl.en    = en;
  assign u_ctl.valid = t2_v_q;

  tcg_unitvec #(
    .FRAC   (COORD_FRAC_BITS),
    .SIDE_W (64)
  ) u_unitvec (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (u_ctl),
    .c0_i    (t2_c_q[0]),
    .c1_i    (t2_c_q[1]),
    .c2_i    (t2_c_q[2]),
    .side_i  (t2_side_q),
    .valid_o (u_valid),
    .side_o  (u_side),
    .s_o     (u_s),
    .t_o     (u_t)
  );

  // P1: source select and scale products.
  logic               p1_v_q;
  logic signed [31:0] p1_s_q, p1_t_q;
  logic signed [47:0] p1_ps_q, p1_pt_q;
  logic signed [31:0] sel_s, sel_t;

  assign sel_s = mode_q[tcg_pkg::MODE_ENVMAP] ? 32'(u_s) : $signed(u_side[31:0]);
  assign sel_t = mode_q[tcg_pkg::MODE_ENVMAP] ? 32'(u_t) : $signed(u_side[63:32]);

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_s_q  <= sel_s;
      p1_t_q  <= sel_t;
      p1_ps_q <= sel_s * $signed(scale_q[15:0]);
      p1_pt_q <= sel_t * $signed(scale_q[31:16]);
    end
  end

  // P2: rounding of the scaled values.
  logic               p2_v_q;
  logic signed [39:0] p2_s_q, p2_t_q;
  logic signed [47:0] rnd_s, rnd_t;

  assign rnd_s = p1_ps_q + 48'sd128;
  assign rnd_t = p1_pt_q + 48'sd128;

  always_ff @(posedge clk_i) begin
    if (en) begin
      p2_s_q <= mode_q[tcg_pkg::MODE_SCALE_S] ? $signed(rnd_s[47:8]) : 40'(p1_s_q);
      p2_t_q <= mode_q[tcg_pkg::MODE_SCALE_T] ? $signed(rnd_t[47:8]) : 40'(p1_t_q);
    end
  end

  // P3: scroll.
  logic               p3_v_q;
  logic signed [40:0] p3_s_q, p3_t_q;
  logic signed [31:0] scr_s, scr_t;

  assign scr_s = mode_q[tcg_pkg::MODE_SCROLL_S] ? $signed(scroll_q[31:0])  : 32'sd0;
  assign scr_t = mode_q[tcg_pkg::MODE_SCROLL_T] ? $signed(scroll_q[63:32]) : 32'sd0;

  always_ff @(posedge clk_i) begin
    if (en) begin
      p3_s_q <= 41'(p2_s_q) + 41'(scr_s);
      p3_t_q <= 41'(p2_t_q) + 41'(scr_t);
    end
  end

  // P4: move to the rotation pivot.
  logic               p4_v_q;
  logic signed [41:0] p4_s0_q, p4_t0_q;
  logic signed [40:0] p4_s_q, p4_t_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      p4_s0_q <= 42'(p3_s_q) - 42'(HALF);
      p4_t0_q <= 42'(p3_t_q) + 42'(HALF);
      p4_s_q  <= p3_s_q;
      p4_t_q  <= p3_t_q;
    end
  end

  // P5: rotation products.
  logic               p5_v_q;
  logic signed [57:0] p5_cs_q, p5_nt_q, p5_ns_q, p5_ct_q;
  logic signed [40:0] p5_s_q, p5_t_q;
  logic signed [15:0] cosv, sinv;

  assign cosv = $signed(rot_q[15:0]);
  assign sinv = $signed(rot_q[31:16]);

  always_ff @(posedge clk_i) begin
    if (en) begin
      p5_cs_q <= p4_s0_q * cosv;
      p5_nt_q <= p4_t0_q * sinv;
      p5_ns_q <= p4_s0_q * sinv;
      p5_ct_q <= p4_t0_q * cosv;
      p5_s_q  <= p4_s_q;
      p5_t_q  <= p4_t_q;
    end
  end

  // P6: rotation sums and rounding.
  logic               p6_v_q;
  logic signed [44:0] p6_rs_q, p6_rt_q;
  logic signed [40:0] p6_s_q, p6_t_q;
  logic signed [58:0] rsum_s, rsum_t;

  assign rsum_s = 59'(p5_cs_q) - 59'(p5_nt_q) + 59'sd8192;
  assign rsum_t = 59'(p5_ns_q) + 59'(p5_ct_q) + 59'sd8192;

  always_ff @(posedge clk_i) begin
    if (en) begin
      p6_rs_q <= $signed(rsum_s[58:14]);
      p6_rt_q <= $signed(rsum_t[58:14]);
      p6_s_q  <= p5_s_q;
      p6_t_q  <= p5_t_q;
    end
  end

  // P7: back from the pivot.
  logic               p7_v_q;
  logic signed [45:0] p7_s_q, p7_t_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (mode_q[tcg_pkg::MODE_ROTATE]) begin
        p7_s_q <= 46'(p6_rs_q) + 46'(HALF);
        p7_t_q <= 46'(p6_rt_q) - 46'(HALF);
      end else begin
        p7_s_q <= 46'(p6_s_q);
        p7_t_q <= 46'(p6_t_q);
      end
    end
  end

  // P8: saturation into the output register.
  logic               o_v_q;
  logic signed [31:0] o_s_q, o_t_q;
  logic               o_sat_q;
  logic signed [31:0] sat_s, sat_t;
  logic               clamp_s, clamp_t;

  always_comb begin
    clamp_s = 1'b1;
    clamp_t = 1'b1;
    if (p7_s_q > 46'sd2147483647) begin
      sat_s = 32'sh7fff_ffff;
    end else if (p7_s_q < -46'sd2147483648) begin
      sat_s = 32'sh8000_0000;
    end else begin
      sat_s   = p7_s_q[31:0];
      clamp_s = 1'b0;
    end
    if (p7_t_q > 46'sd2147483647) begin
      sat_t = 32'sh7fff_ffff;
    end else if (p7_t_q < -46'sd2147483648) begin
      sat_t = 32'sh8000_0000;
    end else begin
      sat_t   = p7_t_q[31:0];
      clamp_t = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      o_s_q   <= sat_s;
      o_t_q   <= sat_t;
      o_sat_q <= clamp_s | clamp_t;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t1_v_q <= 1'b0;
      t2_v_q <= 1'b0;
      p1_v_q <= 1'b0;
      p2_v_q <= 1'b0;
      p3_v_q <= 1'b0;
      p4_v_q <= 1'b0;
      p5_v_q <= 1'b0;
      p6_v_q <= 1'b0;
      p7_v_q <= 1'b0;
      o_v_q  <= 1'b0;
    end else if (en) begin
      t1_v_q <= in_valid_i;
      t2_v_q <= t1_v_q;
      p1_v_q <= u_valid;
      p2_v_q <= p1_v_q;
      p3_v_q <= p2_v_q;
      p4_v_q <= p3_v_q;
      p5_v_q <= p4_v_q;
      p6_v_q <= p5_v_q;
      p7_v_q <= p6_v_q;
      o_v_q  <= p7_v_q;
    end
  end

  // Skid register holds a stalled beat, and the pipeline holds while it is full.
  logic [31:0] sk_s_q, sk_t_q;
  logic        sk_sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sk_v_q <= 1'b0;
    end else if (sk_v_q) begin
      sk_v_q <= out_stall_i;
    end else begin
      sk_v_q <= o_v_q && out_stall_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!sk_v_q) begin
      sk_s_q   <= o_s_q;
      sk_t_q   <= o_t_q;
      sk_sat_q <= o_sat_q;
    end
  end

  assign out_valid_o = sk_v_q | o_v_q;
  assign out_s_o     = sk_v_q ? $signed(sk_s_q) : o_s_q;
  assign out_t_o     = sk_v_q ? $signed(sk_t_q) : o_t_q;
  assign saturated_o = sk_v_q ? sk_sat_q : o_sat_q;

`ifndef NO_ASSERTIONS
  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(sk_v_q) |-> $past(o_v_q && out_stall_i))
    else $error("skid register filled without a stalled result");

  a_skid_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sk_v_q && !out_stall_i) |=> !sk_v_q)
    else $error("skid register not released after its beat was taken");
`endif

endmodule

// File: tb/tb_texcoord_generate_transform.sv
// Self-checking testbench for texcoord_generate_transform: random and directed
// vertices, a fixed-point predictor and an in-order result scoreboard.
// Depends on tcg_pkg, the texcoord_generate_transform RTL and tcg_unitvec.
module tb_texcoord_generate_transform;

  typedef struct {
    logic signed [31:0] s;
    logic signed [31:0] t;
    logic               sat;
  } texcoord_t;

  class texcoord_scoreboard;
    bit [5:0]  mode_q;
    bit [31:0] scale_q;
    bit [63:0] scroll_q;
    bit [31:0] rot_q;
    bit [47:0] row_q [3];
    bit [62:0] trans_q;
    texcoord_t pending_q [$];
    int        mismatches;
    int        beats_in;
    int        beats_out;

    function new();
      mode_q   = tcg_pkg::MODE_RST;
      scale_q  = tcg_pkg::SCALE_RST;
      scroll_q = tcg_pkg::SCROLL_RST;
      rot_q    = tcg_pkg::ROT_RST;
      row_q[0] = tcg_pkg::ROW0_RST;
      row_q[1] = tcg_pkg::ROW1_RST;
      row_q[2] = tcg_pkg::ROW2_RST;
      trans_q  = tcg_pkg::TRANS_RST;
    endfunction

    function void set_reg(tcg_pkg::tcg_cfg_e idx, bit [63:0] v);
      case (idx)
        tcg_pkg::CFG_MODE_FLAGS:  mode_q   = v[5:0];
        tcg_pkg::CFG_SCALE:       scale_q  = v[31:0];
        tcg_pkg::CFG_SCROLL:      scroll_q = v;
        tcg_pkg::CFG_ROT:         rot_q    = v[31:0];
        tcg_pkg::CFG_ROW0:        row_q[0] = v[47:0];
        tcg_pkg::CFG_ROW1:        row_q[1] = v[47:0];
        tcg_pkg::CFG_ROW2:        row_q[2] = v[47:0];
        tcg_pkg::CFG_TRANSLATION: trans_q  = v[62:0];
        default: ;
      endcase
    endfunction

    function bit [63:0] int_sqrt(bit [63:0] x);
      bit [63:0] r;
      bit [63:0] b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
        if (x >= r + b) begin
          x = x - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function longint round_q(longint x, int n);
      return (x + (longint'(1) << (n - 1))) >>> n;
    endfunction

    function longint clamp32(longint v, ref logic sat);
      if (v > 64'sd2147483647) begin
        sat = 1'b1;
        return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
        sat = 1'b1;
        return -64'sd2147483648;
      end
      return v;
    endfunction

    function void note_beat(logic signed [31:0] px, logic signed [31:0] py,
                            logic signed [31:0] pz, logic signed [31:0] ts,
                            logic signed [31:0] tt);
      longint    p [3];
      longint    c [3];
      bit [63:0] m [3];
      bit [63:0] mx, sq, n, q;
      longint    s, t, cs, sn, s0, t0, half;
      logic      sat;
      texcoord_t r;
      half = longint'(1) << 15;
      sat = 1'b0;
      p[0] = longint'(px);
      p[1] = longint'(py);
      p[2] = longint'(pz);
      if (mode_q[tcg_pkg::MODE_ENVMAP]) begin
        mx = 0;
        for (int i = 0; i < 3; i++) begin
          c[i] = 0;
          for (int j = 0; j < 3; j++)
            c[i] += p[j] * longint'($signed(row_q[i][16*j +: 16]));
          c[i] += longint'($signed(trans_q[21*i +: 21])) * 16384;
          m[i] = c[i] < 0 ? -c[i] : c[i];
          if (m[i] > mx) mx = m[i];
        end
        if (mx == 0) begin
          s = 0;
          t = 0;
        end else begin
          while (mx >= (64'd1 << 30)) begin
            mx = mx >> 1;
            for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
          end
          while (mx < (64'd1 << 29)) begin
            mx = mx << 1;
            for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
          end
          sq = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
          n = int_sqrt(sq);
          q = ((m[0] << 16) + n / 2) / n;
          s = c[0] < 0 ? -longint'(q) : longint'(q);
          q = ((m[1] << 16) + n / 2) / n;
          t = c[1] < 0 ? -longint'(q) : longint'(q);
        end
      end else begin
        s = longint'(ts);
        t = longint'(tt);
      end
      if (mode_q[tcg_pkg::MODE_SCALE_S])
        s = round_q(s * longint'($signed(scale_q[15:0])), 8);
      if (mode_q[tcg_pkg::MODE_SCALE_T])
        t = round_q(t * longint'($signed(scale_q[31:16])), 8);
      if (mode_q[tcg_pkg::MODE_SCROLL_S]) s += longint'($signed(scroll_q[31:0]));
      if (mode_q[tcg_pkg::MODE_SCROLL_T]) t += longint'($signed(scroll_q[63:32]));
      if (mode_q[tcg_pkg::MODE_ROTATE]) begin
        cs = longint'($signed(rot_q[15:0]));
        sn = longint'($signed(rot_q[31:16]));
        s0 = s - half;
        t0 = t + half;
        s = round_q(cs * s0 - sn * t0, 14) + half;
        t = round_q(sn * s0 + cs * t0, 14) - half;
      end
      s = clamp32(s, sat);
      t = clamp32(t, sat);
      r.s = s[31:0];
      r.t = t[31:0];
      r.sat = sat;
      pending_q.push_back(r);
      beats_in++;
    endfunction

    task report(string what, longint got, longint want);
      $display("mismatch on result beat %0d: %s got %0h expected %0h",
               beats_out, what, got, want);
      mismatches++;
    endtask

    task check_beat(logic signed [31:0] s, logic signed [31:0] t, logic sat);
      texcoord_t w;
      beats_out++;
      if (pending_q.size() == 0) begin
        report("unexpected beat", 0, 0);
      end else begin
        w = pending_q.pop_front();
        if (s !== w.s) report("out_s", s, w.s);
        if (t !== w.t) report("out_t", t, w.t);
        if (sat !== w.sat) report("saturated", sat, w.sat);
      end
    endtask
  endclass

  localparam int IDLE_LIMIT = 5000;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [2:0]         cfg_idx_i;
  logic [63:0]        cfg_wdata_i;
  logic               in_valid_i;
  logic               in_stall_o;
  logic signed [31:0] pos_x_i, pos_y_i, pos_z_i, tex_s_i, tex_t_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic signed [31:0] out_s_o, out_t_o;
  logic               saturated_o;

  texcoord_scoreboard sb;
  bit hold_req;
  bit no_gaps;
  int idle_cycles;
  int phases;

  texcoord_generate_transform dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        sb.note_beat(pos_x_i, pos_y_i, pos_z_i, tex_s_i, tex_t_i);
      end
      if (out_valid_o && !out_stall_i) begin
        sb.check_beat(out_s_o, out_t_o, saturated_o);
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    int n;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (400) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        n = $urandom_range(0, 9);
        if (n < 6) begin
          out_stall_i <= 1'b0;
          repeat ($urandom_range(1, 20)) @(posedge clk_i);
        end else if (n < 9) begin
          out_stall_i <= 1'b1;
          repeat ($urandom_range(1, 3)) @(posedge clk_i);
        end else begin
          out_stall_i <= 1'b1;
          repeat ($urandom_range(10, 40)) @(posedge clk_i);
        end
      end
    end
  end

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 32'h3_FFFF) - 32'h2_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                             logic [31:0] s, logic [31:0] t);
    int gap;
    gap = 0;
    if (!no_gaps)
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 2);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    pos_x_i <= x;
    pos_y_i <= y;
    pos_z_i <= z;
    tex_s_i <= s;
    tex_t_i <= t;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
  endtask

  task automatic send_random(int count);
    for (int i = 0; i < count; i++)
      send_vertex(pick_word(), pick_word(), pick_word(), pick_word(), pick_word());
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_reg(tcg_pkg::tcg_cfg_e idx, logic [63:0] v);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_reg(idx, v);
  endtask

  task automatic write_all(logic [5:0] mode, logic [31:0] scale, logic [63:0] scroll,
                           logic [31:0] rot, logic [47:0] r0, logic [47:0] r1,
                           logic [47:0] r2, logic [62:0] tr);
    write_reg(tcg_pkg::CFG_MODE_FLAGS, {58'd0, mode});
    write_reg(tcg_pkg::CFG_SCALE, {32'd0, scale});
    write_reg(tcg_pkg::CFG_SCROLL, scroll);
    write_reg(tcg_pkg::CFG_ROT, {32'd0, rot});
    write_reg(tcg_pkg::CFG_ROW0, {16'd0, r0});
    write_reg(tcg_pkg::CFG_ROW1, {16'd0, r1});
    write_reg(tcg_pkg::CFG_ROW2, {16'd0, r2});
    write_reg(tcg_pkg::CFG_TRANSLATION, {1'b0, tr});
    phases++;
  endtask

  task automatic write_random();
    write_all(6'($urandom_range(0, 63)),
              $urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h0200_0200),
              {$urandom, $urandom}, $urandom,
              48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
              48'({$urandom, $urandom}), 63'({$urandom, $urandom}));
  endtask

  initial begin
    sb = new();
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = '0;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    pos_x_i = '0; pos_y_i = '0; pos_z_i = '0; tex_s_i = '0; tex_t_i = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_vertex(0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000);
    send_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_vertex(32'hFFFF_FFFF, 0, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0);
    drain();

    write_all(6'h3F, 32'h7FFF_7FFF, 64'h7FFF_FFFF_7FFF_FFFF, 32'h8000_8000,
              48'h8000_8000_8000, 48'h7FFF_7FFF_7FFF, 48'h8000_7FFF_8000,
              {21'h0F_FFFF, 21'h10_0000, 21'h1F_FFFF});
    send_vertex(0, 0, 0, 0, 0);
    send_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_vertex(32'h100, 32'hFFFF_FF00, 32'h0, 32'h8000, 32'hFFFF_8000);
    drain();

    write_all(6'h01, 32'h8000_8000, 64'h8000_0000_8000_0000, 32'h0000_C000,
              tcg_pkg::ROW0_RST, tcg_pkg::ROW1_RST, tcg_pkg::ROW2_RST,
              tcg_pkg::TRANS_RST);
    send_vertex(0, 0, 0, 32'h1234, 32'h5678);
    send_vertex(32'h100, 0, 0, 0, 0);
    send_vertex(0, 32'hFFFF_FF00, 0, 0, 0);
    send_vertex(0, 0, 32'h7FFF_FFFF, 0, 0);
    send_vertex(1, 1, 1, 0, 0);
    send_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0);
    drain();

    write_all(6'h3E, 32'h8000_8000, 64'h8000_0000_8000_0000, 32'h4000_0000,
              '0, '0, '0, '0);
    send_vertex(0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000);
    send_vertex(0, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF);
    send_vertex(0, 0, 0, 32'h8000, 32'hFFFF_8000);
    drain();

    write_all(6'h21, 32'h0100_0100, '0, tcg_pkg::ROT_RST, '0, '0, '0, '0);
    send_vertex(0, 0, 0, 0, 0);
    send_random(4);
    drain();

    for (int ph = 0; ph < 7; ph++) begin
      write_random();
      no_gaps = (ph == 3);
      if (ph == 4) begin
        hold_req = 1'b1;
        no_gaps = 1'b1;
        send_random(120);
        no_gaps = 1'b0;
      end
      send_random(40);
      drain();
    end
    no_gaps = 1'b0;

    $display("Ran %0d vertices through %0d register settings, including extreme values,",
             sb.beats_in, phases);
    $display("zero-vector environment maps and a long output hold-off.");
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
